FILE: rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg: shared constants, types and table functions
// Widths, fixed-point constants and the quarter-wave sine table builder used
// by the encoder angle to space-vector PWM duty block and its channels.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    // Angle handling: whole degrees over one turn.
    localparam int unsigned ANGLE_STEPS = 360;
    localparam int unsigned ANGLE_W     = 9;
    localparam int unsigned QUARTER     = ANGLE_STEPS / 4;
    localparam int unsigned QADDR_W     = $clog2(QUARTER + 1);

    // Configuration register widths.
    localparam int unsigned POLE_W    = 7;
    localparam int unsigned AMP_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_ANGLE      = 2'd0,
        CFG_POLE_PAIRS      = 2'd1,
        CFG_DRIVE_AMPLITUDE = 2'd2
    } cfg_index_t;

    // Pole pairs times the wrapped mechanical angle, and its quotient by 360.
    // The reciprocal error times the largest product stays below one unit of
    // the quotient, so the result is exact across the whole product range.
    localparam int unsigned PROD_W    = POLE_W + ANGLE_W;
    localparam int unsigned QUOT_W    = $clog2(((1 << PROD_W) - 1) / ANGLE_STEPS + 1);
    localparam int unsigned MOD_SHIFT = 25;
    localparam int unsigned MOD_RW    = 17;
    localparam logic [MOD_RW-1:0] MOD_RECIP =
        MOD_RW'(((64'd1 << MOD_SHIFT) + ANGLE_STEPS - 1) / ANGLE_STEPS);

    // Phase handling: the cosine of each phase is read as sin(angle + offset).
    localparam int unsigned PHASES = 3;
    localparam int unsigned COS_OFFSET [PHASES] = '{90, 330, 210};

    // Sine table precision.
    localparam int unsigned TRIG_FRAC_DEF = 15;
    localparam int unsigned TRIG_FRAC_MAX = 20;
    localparam int unsigned QS_W          = TRIG_FRAC_MAX + 1;
    localparam longint unsigned PI_Q30    = 64'd3373259426;

    // Min-max injection gain 1.1547, applied as 2 * 11547 against 10000.
    localparam int unsigned GAIN_NUM = 11547;
    localparam int unsigned GAIN_DEN = 10000;
    localparam int unsigned GAIN_W   = 16;

    // Duty scaling: divide by 20000 * 2^(F-1) as a shift by F+4 and a
    // reciprocal multiplication for the remaining factor of 625.
    localparam int unsigned DUTY_W         = 16;
    localparam int unsigned DUTY_FULL      = 20000;
    localparam int unsigned DUTY_PRE_SHIFT = 5;
    localparam int unsigned DUTY_DIV       = DUTY_FULL >> DUTY_PRE_SHIFT;
    localparam int unsigned Y_W            = 26;
    localparam int unsigned DUTY_SHIFT     = 36;
    localparam int unsigned RECIP_W        = 27;
    localparam logic [RECIP_W-1:0] DUTY_RECIP =
        RECIP_W'(((64'd1 << DUTY_SHIFT) + DUTY_DIV - 1) / DUTY_DIV);

    typedef logic [QS_W-1:0] qsine_table_t [0:QUARTER];

    // Sine of k degrees by an integer Taylor series to x^15 in Q30, rounded
    // half up to frac_bits fraction bits and clamped to one.
    function automatic logic [QS_W-1:0] quarter_sine(input int unsigned k,
                                                     input int unsigned frac_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - term;
        v    = (sum + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
        if (v > (64'd1 << frac_bits))
        begin
            v = 64'd1 << frac_bits;
        end
        return v[QS_W-1:0];
    endfunction

    function automatic qsine_table_t quarter_table(input int unsigned frac_bits);
        qsine_table_t tab;
        for (int unsigned d = 0; d <= QUARTER; d++)
        begin
            tab[d] = quarter_sine(d, frac_bits);
        end
        return tab;
    endfunction

endpackage

FILE: rtl/svpwm_angle_if.sv
// ----------------------------------------------------------------------------
// svpwm_angle_if: encoder angle channel
// Carries one mechanical angle item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface svpwm_angle_if;

    logic                           valid;
    logic                           ready;
    logic [svpwm_pkg::ANGLE_W-1:0]  raw_angle;

    modport source (output valid, output raw_angle, input ready);
    modport sink   (input valid, input raw_angle, output ready);

endinterface

FILE: rtl/svpwm_duty_if.sv
// ----------------------------------------------------------------------------
// svpwm_duty_if: phase duty channel
// Carries three phase duties and the electrical angle per handshake.
// ----------------------------------------------------------------------------
interface svpwm_duty_if;

    logic                           valid;
    logic                           ready;
    logic [svpwm_pkg::DUTY_W-1:0]   duty_u;
    logic [svpwm_pkg::DUTY_W-1:0]   duty_v;
    logic [svpwm_pkg::DUTY_W-1:0]   duty_w;
    logic [svpwm_pkg::ANGLE_W-1:0]  electrical_angle;

    modport source (output valid, output duty_u, output duty_v, output duty_w,
                    output electrical_angle, input ready);
    modport sink   (input valid, input duty_u, input duty_v, input duty_w,
                    input electrical_angle, output ready);

endinterface

FILE: rtl/encoder_angle_to_svpwm_duty.sv
// ----------------------------------------------------------------------------
// encoder_angle_to_svpwm_duty: encoder angle to space-vector PWM duties
// Converts a mechanical encoder angle into three min-max injected phase
// duties in unsigned Q0.16, together with the electrical angle.
// ----------------------------------------------------------------------------
// The block is a twelve-stage pipeline that accepts one angle item on every
// clock while the output side is ready. Every stage carries a valid bit and
// moves on when it is empty or when the stage after it moves, so a stalled
// output holds its item while the stages behind it keep filling up any
// bubbles; nothing is dropped or repeated. The throughput of one item per
// clock comes from every stage handing on an item each cycle while the
// output is ready; the widest stages, the reciprocal multiplications used
// for the modulo 360 reduction and for the remaining division by 625,
// bound the clock rate instead. The configuration registers (zero angle,
// pole pairs, drive amplitude) are read directly by the pipeline and
// should only be written while no item is in flight. Register indices
// beyond the drive amplitude are ignored. The sine table holds one
// quarter wave of 91 entries built at elaboration; the other quadrants are
// mirrored from it.
// ----------------------------------------------------------------------------
module encoder_angle_to_svpwm_duty #(
    parameter int unsigned TRIG_FRAC_BITS = svpwm_pkg::TRIG_FRAC_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [svpwm_pkg::CFG_W-1:0]      cfg_data,
    svpwm_angle_if.sink                      angle,
    svpwm_duty_if.source                     duty
);

    import svpwm_pkg::*;

    // Fixed-point widths that follow from the sine table precision.
    localparam int unsigned F  = TRIG_FRAC_BITS;
    localparam int unsigned CW = F + 2;     // signed cosine
    localparam int unsigned TW = F + 18;    // signed phase term
    localparam int unsigned SW = F + 19;    // signed max plus min
    localparam int unsigned DW = F + 34;    // signed duty numerator
    localparam int unsigned PW = Y_W + RECIP_W;

    localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (14 + F));
    localparam logic signed [DW-1:0] FULL = DW'(64'(DUTY_FULL) << (15 + F));
    localparam logic signed [GAIN_W-1:0] GAIN2 = GAIN_W'(2 * GAIN_NUM);
    localparam logic signed [GAIN_W-1:0] GDEN  = GAIN_W'(GAIN_DEN);

    localparam qsine_table_t QS_TABLE = quarter_table(F);

    // Pipeline stages, in order.
    localparam int unsigned ST_DIFF  = 0;   // angle minus zero, wrapped
    localparam int unsigned ST_PROD  = 1;   // times pole pairs
    localparam int unsigned ST_QUOT  = 2;   // quotient by 360
    localparam int unsigned ST_ELEC  = 3;   // electrical angle
    localparam int unsigned ST_ADDR  = 4;   // folded table addresses
    localparam int unsigned ST_COS   = 5;   // signed cosines
    localparam int unsigned ST_TERM  = 6;   // phase terms
    localparam int unsigned ST_SUM   = 7;   // max plus min
    localparam int unsigned ST_SCALE = 8;   // gain products
    localparam int unsigned ST_NUM   = 9;   // saturation flags and scaled numerator
    localparam int unsigned ST_RECIP = 10;  // reciprocal product
    localparam int unsigned ST_OUT   = 11;  // output register
    localparam int unsigned NSTAGE   = 12;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] zero_angle_reg;
    logic [POLE_W-1:0]  pole_pairs_reg;
    logic [AMP_W-1:0]   drive_amplitude_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_angle_reg      <= '0;
            pole_pairs_reg      <= POLE_W'(1);
            drive_amplitude_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ZERO_ANGLE:      zero_angle_reg      <= cfg_data[ANGLE_W-1:0];
                CFG_POLE_PAIRS:      pole_pairs_reg      <= cfg_data[POLE_W-1:0];
                CFG_DRIVE_AMPLITUDE: drive_amplitude_reg <= cfg_data[AMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. A stage loads when it is empty or when the stage after
    // it loads; the last stage loads when it is empty or the sink is ready.
    // ------------------------------------------------------------------
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] adv;

    always_comb
    begin
        adv[ST_OUT] = !vld_reg[ST_OUT] || duty.ready;
        for (int i = int'(ST_OUT) - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = vld_reg;
        for (int i = 0; i < int'(NSTAGE); i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = (i == 0) ? angle.valid : vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign angle.ready = adv[ST_DIFF];

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]           diff_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [PROD_W-1:0]            prod_q_reg;
    logic [QUOT_W-1:0]            quot_reg;
    logic [ANGLE_W-1:0]           elec_reg [ST_ELEC:ST_OUT];
    logic [QADDR_W-1:0]           addr_reg [PHASES];
    logic                         neg_reg  [PHASES];
    logic signed [CW-1:0]         cos_reg  [PHASES];
    logic signed [TW-1:0]         term_reg [PHASES];
    logic signed [TW-1:0]         term2_reg [PHASES];
    logic signed [SW-1:0]         sum_reg;
    logic signed [DW-2:0]         scl_reg  [PHASES];
    logic signed [DW-2:0]         off_reg;
    logic                         zero_reg [ST_NUM:ST_RECIP][PHASES];
    logic                         full_reg [ST_NUM:ST_RECIP][PHASES];
    logic [Y_W-1:0]               y_reg    [PHASES];
    logic [PW-1:0]                rec_reg  [PHASES];
    logic [DUTY_W-1:0]            duty_reg [PHASES];

    logic [ANGLE_W-1:0]           diff_next;
    logic [PROD_W-1:0]            prod_next;
    logic [QUOT_W-1:0]            quot_next;
    logic [ANGLE_W-1:0]           elec_next;
    logic [QADDR_W-1:0]           addr_next [PHASES];
    logic                         neg_next  [PHASES];
    logic signed [CW-1:0]         cos_next  [PHASES];
    logic signed [TW-1:0]         term_next [PHASES];
    logic signed [SW-1:0]         sum_next;
    logic signed [DW-2:0]         scl_next  [PHASES];
    logic signed [DW-2:0]         off_next;
    logic                         zero_next [PHASES];
    logic                         full_next [PHASES];
    logic [Y_W-1:0]               y_next    [PHASES];
    logic [PW-1:0]                rec_next  [PHASES];
    logic [DUTY_W-1:0]            duty_next [PHASES];

    // Mechanical angle minus zero angle, wrapped into 0..359. The sum stays
    // below four turns, so at most one of three subtractions applies.
    logic [ANGLE_W+1:0] diff_wide;

    always_comb
    begin
        diff_wide = {2'b00, angle.raw_angle} + (ANGLE_W+2)'(2 * ANGLE_STEPS)
                  - {2'b00, zero_angle_reg};
        priority if (diff_wide >= (ANGLE_W+2)'(3 * ANGLE_STEPS))
        begin
            diff_next = ANGLE_W'(diff_wide - (ANGLE_W+2)'(3 * ANGLE_STEPS));
        end
        else if (diff_wide >= (ANGLE_W+2)'(2 * ANGLE_STEPS))
        begin
            diff_next = ANGLE_W'(diff_wide - (ANGLE_W+2)'(2 * ANGLE_STEPS));
        end
        else if (diff_wide >= (ANGLE_W+2)'(ANGLE_STEPS))
        begin
            diff_next = ANGLE_W'(diff_wide - (ANGLE_W+2)'(ANGLE_STEPS));
        end
        else
        begin
            diff_next = ANGLE_W'(diff_wide);
        end
    end

    // Scale by pole pairs, then reduce modulo 360: the reciprocal gives the
    // exact quotient for every product this stage can see.
    logic [2*MOD_RW-1:0] quot_wide;

    always_comb
    begin
        prod_next = {{(PROD_W-POLE_W){1'b0}}, pole_pairs_reg}
                  * {{(PROD_W-ANGLE_W){1'b0}}, diff_reg};
        quot_wide = (2*MOD_RW)'(prod_reg) * (2*MOD_RW)'(MOD_RECIP);
        quot_next = quot_wide[MOD_SHIFT +: QUOT_W];
        elec_next = ANGLE_W'(prod_q_reg - PROD_W'(quot_reg) * PROD_W'(ANGLE_STEPS));
    end

    // Each phase reads sin(angle + offset). The angle is folded into the
    // first quadrant and the sign is kept aside.
    logic [ANGLE_W:0] sang;

    always_comb
    begin
        sang = '0;
        for (int k = 0; k < int'(PHASES); k++)
        begin
            sang = {1'b0, elec_reg[ST_ELEC]} + (ANGLE_W+1)'(COS_OFFSET[k]);
            if (sang >= (ANGLE_W+1)'(ANGLE_STEPS))
            begin
                sang = sang - (ANGLE_W+1)'(ANGLE_STEPS);
            end
            priority if (sang <= (ANGLE_W+1)'(QUARTER))
            begin
                addr_next[k] = QADDR_W'(sang);
                neg_next[k]  = 1'b0;
            end
            else if (sang <= (ANGLE_W+1)'(2 * QUARTER))
            begin
                addr_next[k] = QADDR_W'((ANGLE_W+1)'(2 * QUARTER) - sang);
                neg_next[k]  = 1'b0;
            end
            else if (sang <= (ANGLE_W+1)'(3 * QUARTER))
            begin
                addr_next[k] = QADDR_W'(sang - (ANGLE_W+1)'(2 * QUARTER));
                neg_next[k]  = 1'b1;
            end
            else
            begin
                addr_next[k] = QADDR_W'((ANGLE_W+1)'(ANGLE_STEPS) - sang);
                neg_next[k]  = 1'b1;
            end
        end
    end

    // Table read, phase terms, and the min-max offset.
    logic [F:0]            qs_val;
    logic signed [SW-1:0]  amp_prod;
    logic signed [TW-1:0]  tmax;
    logic signed [TW-1:0]  tmin;

    always_comb
    begin
        qs_val   = '0;
        amp_prod = '0;
        for (int k = 0; k < int'(PHASES); k++)
        begin
            qs_val = QS_TABLE[addr_reg[k]][F:0];
            cos_next[k] = neg_reg[k] ? -$signed({1'b0, qs_val}) : $signed({1'b0, qs_val});
            amp_prod = $signed({1'b0, drive_amplitude_reg}) * cos_reg[k];
            term_next[k] = TW'(amp_prod + HALF);
        end
        tmax = term_reg[0];
        tmin = term_reg[0];
        for (int k = 1; k < int'(PHASES); k++)
        begin
            if (term_reg[k] > tmax)
            begin
                tmax = term_reg[k];
            end
            if (term_reg[k] < tmin)
            begin
                tmin = term_reg[k];
            end
        end
        sum_next = SW'(tmax) + SW'(tmin);
    end

    // Gain products, then the numerator with its saturation flags. Inside the
    // range the numerator is pre-shifted so that only a division by 625 is
    // left for the reciprocal stage.
    logic signed [DW-1:0] num;

    always_comb
    begin
        num = '0;
        off_next = sum_reg * GDEN;
        for (int k = 0; k < int'(PHASES); k++)
        begin
            scl_next[k]  = term2_reg[k] * GAIN2;
            num          = DW'(scl_reg[k]) - DW'(off_reg);
            zero_next[k] = num[DW-1] || (num == '0);
            full_next[k] = (num >= FULL);
            y_next[k]    = num[F + 4 +: Y_W];
            rec_next[k]  = PW'(y_reg[k]) * PW'(DUTY_RECIP);
            priority if (full_reg[ST_RECIP][k])
            begin
                duty_next[k] = '1;
            end
            else if (zero_reg[ST_RECIP][k])
            begin
                duty_next[k] = '0;
            end
            else
            begin
                duty_next[k] = rec_reg[k][DUTY_SHIFT +: DUTY_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_DIFF])
        begin
            diff_reg <= diff_next;
        end
        if (adv[ST_PROD])
        begin
            prod_reg <= prod_next;
        end
        if (adv[ST_QUOT])
        begin
            quot_reg   <= quot_next;
            prod_q_reg <= prod_reg;
        end
        if (adv[ST_ELEC])
        begin
            elec_reg[ST_ELEC] <= elec_next;
        end
        for (int i = int'(ST_ELEC) + 1; i <= int'(ST_OUT); i++)
        begin
            if (adv[i])
            begin
                elec_reg[i] <= elec_reg[i-1];
            end
        end
        if (adv[ST_SUM])
        begin
            sum_reg <= sum_next;
        end
        if (adv[ST_SCALE])
        begin
            off_reg <= off_next;
        end
        for (int k = 0; k < int'(PHASES); k++)
        begin
            if (adv[ST_ADDR])
            begin
                addr_reg[k] <= addr_next[k];
                neg_reg[k]  <= neg_next[k];
            end
            if (adv[ST_COS])
            begin
                cos_reg[k] <= cos_next[k];
            end
            if (adv[ST_TERM])
            begin
                term_reg[k] <= term_next[k];
            end
            if (adv[ST_SUM])
            begin
                term2_reg[k] <= term_reg[k];
            end
            if (adv[ST_SCALE])
            begin
                scl_reg[k] <= scl_next[k];
            end
            if (adv[ST_NUM])
            begin
                zero_reg[ST_NUM][k] <= zero_next[k];
                full_reg[ST_NUM][k] <= full_next[k];
                y_reg[k]            <= y_next[k];
            end
            if (adv[ST_RECIP])
            begin
                zero_reg[ST_RECIP][k] <= zero_reg[ST_NUM][k];
                full_reg[ST_RECIP][k] <= full_reg[ST_NUM][k];
                rec_reg[k]            <= rec_next[k];
            end
            if (adv[ST_OUT])
            begin
                duty_reg[k] <= duty_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output item.
    // ------------------------------------------------------------------
    assign duty.valid            = vld_reg[ST_OUT];
    assign duty.duty_u           = duty_reg[0];
    assign duty.duty_v           = duty_reg[1];
    assign duty.duty_w           = duty_reg[2];
    assign duty.electrical_angle = elec_reg[ST_OUT];

endmodule
